@@ hdl/sit_pkg.sv @@
// ============================================================================
// sit_pkg: shared constants for the segment intersection test
// Default coordinate width and orientation codes.
// ============================================================================
package sit_pkg;

    // Default width of one coordinate, two's complement.
    localparam int SIT_COORD_WIDTH = 16;

    // Orientation codes (sign of the cross product).
    localparam logic [1:0] ORIENT_COLLINEAR = 2'd0;
    localparam logic [1:0] ORIENT_CW        = 2'd1;
    localparam logic [1:0] ORIENT_CCW       = 2'd2;

endpackage

@@ hdl/sit_pair_if.sv @@
// ============================================================================
// sit_pair_if: segment pair request channel
// Valid/ready channel carrying the endpoints of two 2-D segments.
// ============================================================================
interface sit_pair_if
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = SIT_COORD_WIDTH
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_a_start_x;
    logic signed [COORD_WIDTH-1:0] seg_a_start_y;
    logic signed [COORD_WIDTH-1:0] seg_a_end_x;
    logic signed [COORD_WIDTH-1:0] seg_a_end_y;
    logic signed [COORD_WIDTH-1:0] seg_b_start_x;
    logic signed [COORD_WIDTH-1:0] seg_b_start_y;
    logic signed [COORD_WIDTH-1:0] seg_b_end_x;
    logic signed [COORD_WIDTH-1:0] seg_b_end_y;

    modport source
    (
        output valid,
        input  ready,
        output seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
        output seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    );

    modport sink
    (
        input  valid,
        output ready,
        input  seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
        input  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    );

endinterface

@@ hdl/sit_result_if.sv @@
// ============================================================================
// sit_result_if: intersection result channel
// Valid/ready channel carrying the one-bit intersection flag.
// ============================================================================
interface sit_result_if ();

    logic valid;
    logic ready;
    logic intersects;

    modport source
    (
        output valid,
        input  ready,
        output intersects
    );

    modport sink
    (
        input  valid,
        output ready,
        input  intersects
    );

endinterface

@@ hdl/segment_intersection_test_core.sv @@
// ============================================================================
// segment_intersection_test_core: orientation-based segment intersection test
// Four-stage pipeline: differences, products, cross-product signs, decision.
// ============================================================================
// The accepting edge loads the request into stage 1; it then passes the stage 2,
// stage 3 and output registers (four register stages, stage 1 included).
// Throughput: one request per cycle; the 8 product multipliers of stage 2
// are fully pipelined, nothing iterates. A stall holds only the full stages.
// Reset: rst_n clears all stage valid bits; data registers are not reset.
// ============================================================================
module segment_intersection_test_core
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = SIT_COORD_WIDTH
)
(
    input logic          clk,
    input logic          rst_n,
    sit_pair_if.sink     pair,
    sit_result_if.source result
);

    // Differences need one extra bit, their products twice that, and the
    // difference of two products one more: everything stays exact.
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int VW = PW + 1;

    // Orientation index: 0 = (A,B,C), 1 = (A,B,D), 2 = (C,D,A), 3 = (C,D,B).
    // Per orientation (p,q,r) the four differences are
    //   [0] qy-py   [1] rx-qx   [2] qx-px   [3] ry-qy
    // and the cross product is [0]*[1] - [2]*[3].

    function automatic logic signed [DW-1:0] sub_ext
    (
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return DW'(a) - DW'(b);
    endfunction

    // q inside the bounding box of p and r, bounds inclusive
    function automatic logic in_box
    (
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [COORD_WIDTH-1:0] qx,
        input logic signed [COORD_WIDTH-1:0] qy,
        input logic signed [COORD_WIDTH-1:0] rx,
        input logic signed [COORD_WIDTH-1:0] ry
    );
        logic signed [COORD_WIDTH-1:0] xlo;
        logic signed [COORD_WIDTH-1:0] xhi;
        logic signed [COORD_WIDTH-1:0] ylo;
        logic signed [COORD_WIDTH-1:0] yhi;
        xlo = (px < rx) ? px : rx;
        xhi = (px < rx) ? rx : px;
        ylo = (py < ry) ? py : ry;
        yhi = (py < ry) ? ry : py;
        return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    assign en4 = !out_valid_reg || result.ready;
    assign en3 = !s3_valid_reg  || en4;
    assign en2 = !s2_valid_reg  || en3;
    assign en1 = !s1_valid_reg  || en2;

    assign pair.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= pair.valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: endpoint differences and bounding-box flags
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    assign ax = pair.seg_a_start_x;
    assign ay = pair.seg_a_start_y;
    assign bx = pair.seg_a_end_x;
    assign by = pair.seg_a_end_y;
    assign cx = pair.seg_b_start_x;
    assign cy = pair.seg_b_start_y;
    assign dx = pair.seg_b_end_x;
    assign dy = pair.seg_b_end_y;

    logic signed [DW-1:0] s1_diff_next [4][4];
    logic [3:0]           s1_box_next;
    logic signed [DW-1:0] s1_diff_reg  [4][4];
    logic [3:0]           s1_box_reg;

    always_comb
    begin
        // (A,B,C)
        s1_diff_next[0][0] = sub_ext(by, ay);
        s1_diff_next[0][1] = sub_ext(cx, bx);
        s1_diff_next[0][2] = sub_ext(bx, ax);
        s1_diff_next[0][3] = sub_ext(cy, by);
        // (A,B,D)
        s1_diff_next[1][0] = sub_ext(by, ay);
        s1_diff_next[1][1] = sub_ext(dx, bx);
        s1_diff_next[1][2] = sub_ext(bx, ax);
        s1_diff_next[1][3] = sub_ext(dy, by);
        // (C,D,A)
        s1_diff_next[2][0] = sub_ext(dy, cy);
        s1_diff_next[2][1] = sub_ext(ax, dx);
        s1_diff_next[2][2] = sub_ext(dx, cx);
        s1_diff_next[2][3] = sub_ext(ay, dy);
        // (C,D,B)
        s1_diff_next[3][0] = sub_ext(dy, cy);
        s1_diff_next[3][1] = sub_ext(bx, dx);
        s1_diff_next[3][2] = sub_ext(dx, cx);
        s1_diff_next[3][3] = sub_ext(by, dy);

        s1_box_next[0] = in_box(ax, ay, cx, cy, bx, by);   // C on A's box
        s1_box_next[1] = in_box(ax, ay, dx, dy, bx, by);   // D on A's box
        s1_box_next[2] = in_box(cx, cy, ax, ay, dx, dy);   // A on B's box
        s1_box_next[3] = in_box(cx, cy, bx, by, dx, dy);   // B on B's box
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_diff_reg <= s1_diff_next;
            s1_box_reg  <= s1_box_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the eight cross-product terms
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s2_prod_next [4][2];
    logic signed [PW-1:0] s2_prod_reg  [4][2];
    logic [3:0]           s2_box_reg;

    always_comb
    begin
        for (int o = 0; o < 4; o++)
        begin
            s2_prod_next[o][0] = PW'(s1_diff_reg[o][0]) * PW'(s1_diff_reg[o][1]);
            s2_prod_next[o][1] = PW'(s1_diff_reg[o][2]) * PW'(s1_diff_reg[o][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_box_reg  <= s1_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross product and its sign as an orientation code
    // ------------------------------------------------------------------
    logic signed [VW-1:0] s3_val [4];
    logic [1:0]           s3_code_next [4];
    logic [1:0]           s3_code_reg  [4];
    logic [3:0]           s3_box_reg;

    always_comb
    begin
        for (int o = 0; o < 4; o++)
        begin
            s3_val[o] = VW'(s2_prod_reg[o][0]) - VW'(s2_prod_reg[o][1]);
            if (s3_val[o] == '0)
                s3_code_next[o] = ORIENT_COLLINEAR;
            else if (s3_val[o][VW-1])
                s3_code_next[o] = ORIENT_CCW;
            else
                s3_code_next[o] = ORIENT_CW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_code_reg <= s3_code_next;
            s3_box_reg  <= s2_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: decision. Proper crossing when both orientation pairs
    // differ; otherwise a collinear endpoint inside the other box.
    // ------------------------------------------------------------------
    logic hit_next;
    logic out_hit_reg;

    always_comb
    begin
        hit_next = ((s3_code_reg[0] != s3_code_reg[1]) &&
                    (s3_code_reg[2] != s3_code_reg[3]));
        for (int o = 0; o < 4; o++)
        begin
            if ((s3_code_reg[o] == ORIENT_COLLINEAR) && s3_box_reg[o])
                hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
            out_hit_reg <= hit_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.intersects = out_hit_reg;

endmodule
